@@ sv/ecc_pkg.sv @@
// Shared types and constants of the event coincidence counter.
package ecc_pkg;

    localparam int MODE_W  = 2;
    localparam int EVENT_W = 16;
    localparam int IDX_W   = 4;
    localparam int OUT_W   = 32;
    localparam int DELTA_W = 4;

    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic REG_DELTA = 1'b0;
    localparam logic REG_KIND  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_PEND
    } t_state;

    typedef struct packed {
        logic step;
        logic clear;
    } t_ctl;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_rd_tag;

endpackage

@@ sv/ecc_in_if.sv @@
// Input item channel: mode, events and the pair to read.
interface ecc_in_if import ecc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [EVENT_W-1:0] events;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;

    modport source (output valid, output mode, output events, output row, output col,
                    input ready);
    modport sink   (input valid, input mode, input events, input row, input col,
                    output ready);
endinterface

@@ sv/ecc_out_if.sv @@
// Result channel: one count with its saturate flag.
interface ecc_out_if import ecc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] count;
    logic             saturated;

    modport source (output valid, output count, output saturated, input ready);
    modport sink   (input valid, input count, input saturated, output ready);
endinterface

@@ sv/event_coincidence_counter.sv @@
// Top level: config registers, row of counter cells, history unit and result register.
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    mode, events, row, col
//  o_out    out  valid/ready    count, saturated
//  apb      in   psel/penable   paddr, pwdata -> prdata (delta at 0, coincidence_kind at 4)
//
// Sample and clear items may follow back to back while no read is in progress.
// A read walks the row of NUM_SERIES cells, one cell per cycle, and lands in the
// output register, or the pending register if the output is stalled; no item is taken
// meanwhile, so the next transfer waits until the result is in the output register.
// Synchronous reset clears history and all counters at once; no clearing pass.
// A result held by a stalled output keeps the next read's result in a pending register
// and holds off further items until it moves on.
module event_coincidence_counter import ecc_pkg::*; #(
    parameter int NUM_SERIES = 16,
    parameter int MAX_WINDOW = 15,
    parameter int COUNT_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ecc_in_if.sink        i_in,
    ecc_out_if.source     o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [DELTA_W-1:0] r_delta;
    logic               r_kind;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= '0;
            r_kind  <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_DELTA: r_delta <= pwdata[DELTA_W-1:0];
                REG_KIND:  r_kind  <= pwdata[0];
                default:   r_kind  <= r_kind;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DELTA: prdata = 32'(r_delta);
            REG_KIND:  prdata = 32'(r_kind);
            default:   prdata = '0;
        endcase
    end

    t_state                r_state, n_state;
    logic                  in_ready;
    logic                  accept;
    t_ctl                  ctl;
    t_rd_tag               req_tag;
    logic [NUM_SERIES-1:0] ev;
    logic [NUM_SERIES-1:0] rmask, cmask;
    logic                  count_en;
    t_ctl                  cell_ctl;

    assign in_ready   = (r_state == S_IDLE);
    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    assign ctl.step  = accept && (i_in.mode == MODE_SAMPLE);
    assign ctl.clear = accept && (i_in.mode == MODE_CLEAR);

    assign req_tag.valid = accept && (i_in.mode == MODE_READ);
    assign req_tag.row   = i_in.row;
    assign req_tag.col   = i_in.col;

    for (genvar s = 0; s < NUM_SERIES; s++) begin : g_ev
        if (s < EVENT_W) begin : g_in
            assign ev[s] = i_in.events[s];
        end else begin : g_zero
            assign ev[s] = 1'b0;
        end
    end

    ecc_history #(
        .NUM_SERIES (NUM_SERIES),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_history (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_events   (ev),
        .i_delta    (r_delta),
        .i_kind     (r_kind),
        .o_rmask    (rmask),
        .o_cmask    (cmask),
        .o_count_en (count_en)
    );

    assign cell_ctl.step  = count_en;
    assign cell_ctl.clear = ctl.clear;

    t_rd_tag               link_tag [0:NUM_SERIES];
    logic [COUNT_BITS-1:0] link_cnt [0:NUM_SERIES];
    logic                  link_sat [0:NUM_SERIES];

    assign link_tag[0] = req_tag;
    assign link_cnt[0] = '0;
    assign link_sat[0] = 1'b0;

    for (genvar r = 0; r < NUM_SERIES; r++) begin : g_cell
        ecc_cell #(
            .NUM_SERIES (NUM_SERIES),
            .COUNT_BITS (COUNT_BITS),
            .ROW        (r)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (cell_ctl),
            .i_row_hit (rmask[r]),
            .i_cmask   (cmask),
            .i_tag     (link_tag[r]),
            .i_count   (link_cnt[r]),
            .i_sat     (link_sat[r]),
            .o_tag     (link_tag[r+1]),
            .o_count   (link_cnt[r+1]),
            .o_sat     (link_sat[r+1])
        );
    end

    logic [63:0]      end_wide;
    logic [OUT_W-1:0] end_count;
    logic             end_valid;

    assign end_wide  = 64'(link_cnt[NUM_SERIES]);
    assign end_count = end_wide[OUT_W-1:0];
    assign end_valid = link_tag[NUM_SERIES].valid;

    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_count, n_out_count;
    logic             r_out_sat, n_out_sat;
    logic [OUT_W-1:0] r_pend_count, n_pend_count;
    logic             r_pend_sat, n_pend_sat;
    logic             out_free;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_out_count  = r_out_count;
        n_out_sat    = r_out_sat;
        n_pend_count = r_pend_count;
        n_pend_sat   = r_pend_sat;
        out_free     = !r_out_valid || o_out.ready;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (req_tag.valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (end_valid) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_count = end_count;
                        n_out_sat   = link_sat[NUM_SERIES];
                        n_state     = S_IDLE;
                    end else begin
                        n_pend_count = end_count;
                        n_pend_sat   = link_sat[NUM_SERIES];
                        n_state      = S_PEND;
                    end
                end
            end
            S_PEND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_pend_count;
                    n_out_sat   = r_pend_sat;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_count  <= n_out_count;
        r_out_sat    <= n_out_sat;
        r_pend_count <= n_pend_count;
        r_pend_sat   <= n_pend_sat;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.count     = r_out_count;
    assign o_out.saturated = r_out_sat;

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_tag.valid |-> ##(NUM_SERIES) link_tag[NUM_SERIES].valid)
        else $error("read did not reach the end of the cell row in time");

    a_end_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        link_tag[NUM_SERIES].valid |-> (r_state == S_READ))
        else $error("read data left the cell row outside a read");

    a_pend_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PEND) |-> r_out_valid)
        else $error("pending result with an empty output register");

endmodule

@@ sv/ecc_history.sv @@
// Event history, per-series event age and step count; forms the row and column masks.
module ecc_history import ecc_pkg::*; #(
    parameter int NUM_SERIES = 16,
    parameter int MAX_WINDOW = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    input  logic [NUM_SERIES-1:0] i_events,
    input  logic [DELTA_W-1:0]    i_delta,
    input  logic                  i_kind,
    output logic [NUM_SERIES-1:0] o_rmask,
    output logic [NUM_SERIES-1:0] o_cmask,
    output logic                  o_count_en
);

    localparam int W  = (MAX_WINDOW > 0) ? $clog2(MAX_WINDOW + 1) : 1;
    localparam int AW = $clog2(MAX_WINDOW + 2);
    localparam logic [AW-1:0] AGE_MAX = AW'(MAX_WINDOW + 1);

    logic [NUM_SERIES-1:0] r_hist [0:MAX_WINDOW];
    logic [NUM_SERIES-1:0] n_hist [0:MAX_WINDOW];
    logic [AW-1:0]         r_age  [NUM_SERIES];
    logic [AW-1:0]         n_age  [NUM_SERIES];
    logic [W-1:0]          r_steps, n_steps;

    logic [8:0]            delta_w, win_w;
    logic [W-1:0]          win;
    logic [NUM_SERIES-1:0] any;

    always_comb begin
        delta_w = 9'(i_delta);
        win_w   = (delta_w > 9'(MAX_WINDOW)) ? 9'(MAX_WINDOW) : delta_w;
        win     = win_w[W-1:0];

        n_hist[0] = i_events;
        for (int k = 1; k <= MAX_WINDOW; k++) begin
            n_hist[k] = r_hist[k-1];
        end
        for (int s = 0; s < NUM_SERIES; s++) begin
            if (i_events[s]) begin
                n_age[s] = '0;
            end else if (r_age[s] == AGE_MAX) begin
                n_age[s] = AGE_MAX;
            end else begin
                n_age[s] = r_age[s] + AW'(1);
            end
            any[s] = (n_age[s] <= AW'(win));
        end

        if (i_kind) begin
            o_rmask = any;
            o_cmask = i_events;
        end else begin
            o_rmask = n_hist[win];
            o_cmask = any;
        end
        o_count_en = i_ctl.step && (r_steps >= win);

        n_steps = (r_steps < W'(MAX_WINDOW)) ? r_steps + W'(1) : r_steps;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int k = 0; k <= MAX_WINDOW; k++) begin
                r_hist[k] <= '0;
            end
            for (int s = 0; s < NUM_SERIES; s++) begin
                r_age[s] <= AGE_MAX;
            end
            r_steps <= '0;
        end else if (i_ctl.step) begin
            r_hist  <= n_hist;
            r_age   <= n_age;
            r_steps <= n_steps;
        end
    end

endmodule

@@ sv/ecc_cell.sv @@
// One row of pair counters; passes the read request and data on to the next row.
module ecc_cell import ecc_pkg::*; #(
    parameter int NUM_SERIES = 16,
    parameter int COUNT_BITS = 32,
    parameter int ROW        = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    input  logic                  i_row_hit,
    input  logic [NUM_SERIES-1:0] i_cmask,
    input  t_rd_tag               i_tag,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic                  i_sat,
    output t_rd_tag               o_tag,
    output logic [COUNT_BITS-1:0] o_count,
    output logic                  o_sat
);

    logic [COUNT_BITS-1:0] r_cnt [NUM_SERIES];
    logic [COUNT_BITS-1:0] n_cnt [NUM_SERIES];
    logic [NUM_SERIES-1:0] r_flag, n_flag;

    t_rd_tag               r_tag;
    logic [COUNT_BITS-1:0] r_link_count, n_link_count;
    logic                  r_link_sat, n_link_sat;

    logic [COUNT_BITS-1:0] sel_cnt;
    logic                  sel_flag;
    logic                  hit;

    always_comb begin
        for (int c = 0; c < NUM_SERIES; c++) begin
            n_cnt[c]  = r_cnt[c];
            n_flag[c] = r_flag[c];
            if (i_ctl.clear) begin
                n_cnt[c]  = '0;
                n_flag[c] = 1'b0;
            end else if (i_ctl.step && i_row_hit && i_cmask[c]) begin
                if (&r_cnt[c]) begin
                    n_flag[c] = 1'b1;
                end else begin
                    n_cnt[c] = r_cnt[c] + COUNT_BITS'(1);
                end
            end
        end
    end

    always_comb begin
        sel_cnt  = '0;
        sel_flag = 1'b0;
        for (int c = 0; c < NUM_SERIES; c++) begin
            if (32'(i_tag.col) == 32'(c)) begin
                sel_cnt  = r_cnt[c];
                sel_flag = r_flag[c];
            end
        end
        hit          = i_tag.valid && (32'(i_tag.row) == 32'(ROW));
        n_link_count = hit ? sel_cnt : i_count;
        n_link_sat   = hit ? sel_flag : i_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_SERIES; c++) begin
                r_cnt[c] <= '0;
            end
            r_flag <= '0;
            r_tag  <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_flag <= n_flag;
            r_tag  <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link_count <= n_link_count;
        r_link_sat   <= n_link_sat;
    end

    assign o_tag   = r_tag;
    assign o_count = r_link_count;
    assign o_sat   = r_link_sat;

endmodule
